// File: rtl/core/per_client_token_bucket_limiter_unit_defines.svh
// ----------------------------------------------------------------------------
// limiter assertion macros
// shared property shapes for the token bucket limiter, clocked on clk and
// held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_UNIT_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_UNIT_DEFINES_SVH

// condition holds at every edge
`define PCTBL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PCTBL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PCTBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pctbl_pkg.sv
// ----------------------------------------------------------------------------
// pctbl_pkg
// sizes, register map and controller/datapath interface types of the limiter
// ----------------------------------------------------------------------------
package pctbl_pkg;

	localparam int CLIENTS = 256;
	localparam int SLOT_W  = $clog2(CLIENTS);
	localparam int CNT_W   = $clog2(CLIENTS + 1);

	localparam int IDX_W   = 8;
	localparam int TIME_W  = 32;
	localparam int RATE_W  = 24;
	localparam int TOK_W   = 40;
	localparam int SEC_W   = 16;
	localparam int MS_W    = 26;
	localparam int PROD_W  = TIME_W + RATE_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int STAT_W  = 32;
	localparam int ACT_W   = 9;
	localparam int OUT_W   = 80;
	localparam int IN_W    = 40;
	localparam int MEM_W   = TOK_W + TIME_W;

	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;

	localparam int MS_PER_S = 1000;
	localparam logic [TOK_W-1:0]  ONE_TOKEN = TOK_W'(1000000);
	localparam logic [STAT_W-1:0] STAT_MAX  = '1;

	// register index, byte address is 8 times this
	typedef enum logic [2:0] {
		REG_ENABLED  = 3'd0,
		REG_RATE     = 3'd1,
		REG_BURST    = 3'd2,
		REG_INTERVAL = 3'd3,
		REG_EXPIRY   = 3'd4
	} pctbl_reg_t;

	typedef struct packed {
		logic              enabled;
		logic [RATE_W-1:0] rate;
		logic [TOK_W-1:0]  burst;
		logic [MS_W-1:0]   interval_ms;
		logic [MS_W-1:0]   expiry_ms;
	} pctbl_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;     // latch the accepted word
		logic decide;      // load the early allowed bit
		logic allow_val;   // its value
		logic clear;       // zero both counters
		logic count_req;   // count one request
		logic sweep_start; // note sweep time, restart scan index
		logic sweep_rd;    // read the entry under the scan index
		logic slot_rd;     // read the requesting slot
		logic mul;         // elapsed times rate
		logic upd;         // refill, spend, write back
		logic load_out;    // move result into output register
	} pctbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic enabled;
		logic sweep_due;
		logic sweep_last;
		logic out_free;
	} pctbl_sts_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] index);
		return SLOT_W'(32'(index) % CLIENTS);
	endfunction

endpackage

// File: rtl/core/pctbl_regs.sv
// ----------------------------------------------------------------------------
// pctbl_regs
// configuration register file behind the register port
// ----------------------------------------------------------------------------
module pctbl_regs
	import pctbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output pctbl_cfg_t        cfg
);

	logic              enabled_q;
	logic [RATE_W-1:0] rate_q;
	logic [TOK_W-1:0]  burst_q;
	logic [SEC_W-1:0]  interval_q;
	logic [SEC_W-1:0]  expiry_q;
	logic [MS_W-1:0]   interval_ms_q;
	logic [MS_W-1:0]   expiry_ms_q;
	logic              wr_en;
	pctbl_reg_t        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = pctbl_reg_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b1;
			rate_q     <= RATE_W'(10000);
			burst_q    <= TOK_W'(20000000);
			interval_q <= SEC_W'(60);
			expiry_q   <= SEC_W'(300);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENABLED:  enabled_q  <= pwdata[0];
				REG_RATE:     rate_q     <= pwdata[RATE_W-1:0];
				REG_BURST:    burst_q    <= pwdata[TOK_W-1:0];
				REG_INTERVAL: interval_q <= pwdata[SEC_W-1:0];
				REG_EXPIRY:   expiry_q   <= pwdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// seconds to ms, so elapsed tests need no divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_ms_q <= MS_W'(60000);
			expiry_ms_q   <= MS_W'(300000);
		end else begin
			interval_ms_q <= MS_W'(interval_q) * MS_W'(MS_PER_S);
			expiry_ms_q   <= MS_W'(expiry_q) * MS_W'(MS_PER_S);
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ENABLED:  prdata = DATA_W'(enabled_q);
			REG_RATE:     prdata = DATA_W'(rate_q);
			REG_BURST:    prdata = DATA_W'(burst_q);
			REG_INTERVAL: prdata = DATA_W'(interval_q);
			REG_EXPIRY:   prdata = DATA_W'(expiry_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.enabled     = enabled_q;
	assign cfg.rate        = rate_q;
	assign cfg.burst       = burst_q;
	assign cfg.interval_ms = interval_ms_q;
	assign cfg.expiry_ms   = expiry_ms_q;

endmodule

// File: rtl/core/pctbl_ctrl.sv
// ----------------------------------------------------------------------------
// pctbl_ctrl
// sequencer for one word: decide, optional sweep, read, multiply, update
// ----------------------------------------------------------------------------
module pctbl_ctrl
	import pctbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pctbl_sts_t sts,
	output pctbl_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_CHECK     = 7'b0000010,
		ST_SWEEP     = 7'b0000100,
		ST_SWEEP_END = 7'b0001000,
		ST_CALC      = 7'b0010000,
		ST_UPD       = 7'b0100000,
		ST_DONE      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.decide    = 1'b1;
				cmd.allow_val = !sts.is_clear && !sts.enabled;
				priority if (sts.is_clear) begin
					cmd.clear = 1'b1;
					state_d   = ST_DONE;
				end else if (!sts.enabled) begin
					state_d = ST_DONE;
				end else if (sts.sweep_due) begin
					cmd.count_req   = 1'b1;
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					cmd.count_req = 1'b1;
					cmd.slot_rd   = 1'b1;
					state_d       = ST_CALC;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (sts.sweep_last) state_d = ST_SWEEP_END;
			end
			ST_SWEEP_END: begin
				cmd.slot_rd = 1'b1;
				state_d     = ST_CALC;
			end
			ST_CALC: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/pctbl_dp.sv
// ----------------------------------------------------------------------------
// pctbl_dp
// bucket memory, valid bits, counters, refill arithmetic, output register
// ----------------------------------------------------------------------------
`include "per_client_token_bucket_limiter_unit_defines.svh"

module pctbl_dp
	import pctbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  pctbl_cfg_t        cfg,
	input  pctbl_cmd_t        cmd,
	output pctbl_sts_t        sts,
	input  logic              in_command,
	input  logic [IDX_W-1:0]  in_client_index,
	input  logic [TIME_W-1:0] in_now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  out_data
);

	// captured word
	logic              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] now_q;

	logic [CLIENTS-1:0] valid_q;
	logic [CNT_W-1:0]   vcnt_q;
	logic [TIME_W-1:0]  last_sweep_q;
	logic [STAT_W-1:0]  req_q;
	logic [STAT_W-1:0]  blk_q;
	logic               allow_q;

	// sweep scan and check stage
	logic [SLOT_W-1:0] sweep_idx_q;
	logic              chk_en_q;
	logic [SLOT_W-1:0] chk_idx_q;
	logic              expire;

	// bucket memory: tokens in the upper bits, last refill below
	logic [MEM_W-1:0]  mem [CLIENTS];
	logic [MEM_W-1:0]  rd_q;
	logic [SLOT_W-1:0] rd_addr;
	logic              rd_en;
	logic [TOK_W-1:0]  rd_tokens;
	logic [TIME_W-1:0] rd_last;

	// refill arithmetic
	logic [PROD_W-1:0] prod_q;
	logic [TOK_W-1:0]  base_q;
	logic              new_q;
	logic [TIME_W-1:0] diff;
	logic [SUM_W-1:0]  sum;
	logic [TOK_W-1:0]  capped;
	logic              pass;
	logic [TOK_W-1:0]  new_tok;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	assign rd_tokens = rd_q[MEM_W-1:TIME_W];
	assign rd_last   = rd_q[TIME_W-1:0];
	assign rd_addr   = cmd.sweep_rd ? sweep_idx_q : slot_q;
	assign rd_en     = cmd.sweep_rd | cmd.slot_rd;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_command;
			slot_q <= slot_of(in_client_index);
			now_q  <= in_now_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) mem[slot_q] <= {new_tok, now_q};
		if (rd_en)   rd_q <= mem[rd_addr];
	end

	assign expire = chk_en_q && valid_q[chk_idx_q] &&
		((now_q - rd_last) >= TIME_W'(cfg.expiry_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_en_q    <= 1'b0;
			chk_idx_q   <= '0;
			sweep_idx_q <= '0;
		end else begin
			chk_en_q  <= cmd.sweep_rd;
			chk_idx_q <= sweep_idx_q;
			if (cmd.sweep_start)   sweep_idx_q <= '0;
			else if (cmd.sweep_rd) sweep_idx_q <= sweep_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vcnt_q  <= '0;
		end else begin
			if (expire) begin
				valid_q[chk_idx_q] <= 1'b0;
				vcnt_q             <= vcnt_q - 1'b1;
			end else if (cmd.upd && new_q) begin
				valid_q[slot_q] <= 1'b1;
				vcnt_q          <= vcnt_q + 1'b1;
			end
		end
	end

	// a missing bucket starts full with no elapsed time
	assign diff = now_q - rd_last;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			new_q <= !valid_q[slot_q];
			if (valid_q[slot_q]) begin
				base_q <= rd_tokens;
				prod_q <= PROD_W'(diff) * PROD_W'(cfg.rate);
			end else begin
				base_q <= cfg.burst;
				prod_q <= '0;
			end
		end
	end

	assign sum     = SUM_W'(base_q) + SUM_W'(prod_q);
	assign capped  = (sum > SUM_W'(cfg.burst)) ? cfg.burst : sum[TOK_W-1:0];
	assign pass    = capped >= ONE_TOKEN;
	assign new_tok = pass ? (capped - ONE_TOKEN) : capped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sweep_q <= '0;
			req_q        <= '0;
			blk_q        <= '0;
			allow_q      <= 1'b0;
		end else begin
			if (cmd.sweep_start) last_sweep_q <= now_q;
			if (cmd.decide)      allow_q      <= cmd.allow_val;
			else if (cmd.upd)    allow_q      <= pass;
			if (cmd.clear) begin
				req_q <= '0;
				blk_q <= '0;
			end else begin
				if (cmd.count_req && req_q != STAT_MAX) req_q <= req_q + 1'b1;
				if (cmd.upd && !pass && blk_q != STAT_MAX) blk_q <= blk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_data_q <= OUT_W'({ACT_W'(vcnt_q), blk_q, req_q, allow_q});
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.is_clear   = cmd_q;
	assign sts.enabled    = cfg.enabled;
	assign sts.sweep_due  = (now_q - last_sweep_q) >= TIME_W'(cfg.interval_ms);
	assign sts.sweep_last = (sweep_idx_q == SLOT_W'(CLIENTS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	`PCTBL_ASSERT_ALWAYS(a_vcnt_matches_valid, vcnt_q == CNT_W'($countones(valid_q)), "active count differs from valid bits")
	`PCTBL_ASSERT_IMPLIES(a_no_update_during_check, chk_en_q, !cmd.upd, "bucket update overlaps sweep check")
	`PCTBL_ASSERT_NEXT(a_req_only_moves_when_told, !cmd.clear && !cmd.count_req, req_q == $past(req_q), "request count changed without command")
	`PCTBL_ASSERT_IMPLIES(a_load_only_when_free, cmd.load_out, !out_valid_q || out_ready, "result overwrites a waiting word")

endmodule

// File: rtl/core/per_client_token_bucket_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter_unit
// per-client token bucket rate limiter with counters and idle-bucket sweep
// ----------------------------------------------------------------------------
// a request word names a client slot and the current ms time; the slot's
// bucket is refilled by elapsed ms times rate (capped at burst), and if it
// holds one token (1000000 micro-tokens) one is spent and the request passes.
// a clear word zeroes both counters and returns allowed 0; with the limiter
// disabled every request passes and nothing changes. a request runs through
// decide with bucket read, multiply, refill/write, result load and idle
// before the next acceptance, a clear or disabled word through decide,
// result load and idle. when the cleanup interval has run out the request
// first scans the whole table through the single memory read port, one
// entry a cycle, before its own bucket is read. the result sits in an output
// register, so the next word is taken while it waits for m_tready.
// ----------------------------------------------------------------------------
module per_client_token_bucket_limiter_unit
	import pctbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	// register port, registers at byte address 8 * index
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,

	// request words
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // client_index[7:0], now_ms[39:8]
	input  logic              s_tuser,  // command: 0 request, 1 clear counters

	// result words
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // allowed[0], request_total[32:1],
	                                    // refused_total[64:33],
	                                    // live_buckets[73:65], zero[79:74]
);

	pctbl_cfg_t cfg;
	pctbl_cmd_t cmd;
	pctbl_sts_t sts;

	// configuration registers, seconds pre-scaled to ms
	pctbl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: takes a word only when idle
	pctbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bucket table, counters and result register
	pctbl_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.in_command      (s_tuser),
		.in_client_index (s_tdata[IDX_W-1:0]),
		.in_now_ms       (s_tdata[IDX_W +: TIME_W]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_data        (m_tdata)
	);

endmodule
